>>> src/sequence_reorder_playout_buffer_defines.svh
// assertion macros shared by the checkers of the playout buffer
`ifndef SEQUENCE_REORDER_PLAYOUT_BUFFER_DEFINES_SVH
`define SEQUENCE_REORDER_PLAYOUT_BUFFER_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define SQRB_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sqrb check failed");

// next-cycle implication, sampled on clock, off while reset is high
`define SQRB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sqrb check failed");

`endif

>>> src/sqrb_pkg.sv
`default_nettype none
package sqrb_pkg;

   // ring depth must be a power of two: slot index is the low bits of seq
   localparam int RING_DEPTH = 16;
   localparam int HALF_DEPTH = RING_DEPTH >> 1;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 96;

   localparam logic [1:0] KIND_DELIVER = 2'd0;
   localparam logic [1:0] KIND_MISS    = 2'd1;
   localparam logic [1:0] KIND_REJECT  = 2'd2;

   typedef struct packed {
      logic [31:0] seq;
      logic [15:0] handle;
      logic [10:0] len;
   } slot_entry_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] seq;
      logic [31:0] miss;
      logic [15:0] handle;
      logic [10:0] len;
      logic        last;
   } rsp_item_type;

endpackage
`default_nettype wire

>>> src/sqrb_alu.sv
`default_nettype none
module sqrb_alu (
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   input  wire logic        sub,
   output logic [31:0]      res,
   output logic             borrow,
   output logic             zero
);
   logic [32:0] sum;

   // one 33-bit adder; subtract as a plus inverted b plus one
   assign sum    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {32'd0, sub};
   assign res    = sum[31:0];
   assign borrow = sub & ~sum[32];
   assign zero   = (sum[31:0] == 32'd0);

endmodule
`default_nettype wire

>>> src/sqrb_ring.sv
`default_nettype none
module sqrb_ring (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_en,
   input  wire logic [sqrb_pkg::IDX_W-1:0]  wr_idx,
   input  wire sqrb_pkg::slot_entry_type    wr_entry,
   input  wire logic                        clr_en,
   input  wire logic [sqrb_pkg::IDX_W-1:0]  rd_idx,
   output logic                             rd_valid,
   output sqrb_pkg::slot_entry_type         rd_entry
);
   import sqrb_pkg::*;

   logic [RING_DEPTH-1:0] valid_ff;
   logic [RING_DEPTH-1:0] valid_in;
   slot_entry_type        entry_ff [RING_DEPTH];

   always_comb begin
      valid_in = valid_ff;
      if (clr_en) begin
         valid_in[rd_idx] = 1'b0;
      end
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_idx] <= wr_entry;
      end
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_entry = entry_ff[rd_idx];

endmodule
`default_nettype wire

>>> src/sqrb_outq.sv
`default_nettype none
module sqrb_outq (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push_valid,
   input  wire sqrb_pkg::rsp_item_type         push_item,
   output logic                                push_ready,
   input  wire logic                           flush,
   output logic                                flush_done,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [sqrb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast
);
   import sqrb_pkg::*;

   // pending stage holds one result until it is known whether it is the last
   logic         pend_valid_ff, pend_valid_in;
   rsp_item_type pend_ff, pend_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;
   logic         out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign push_ready = !pend_valid_ff || out_free;
   assign flush_done = !pend_valid_ff || out_free;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      if (push_valid && push_ready) begin
         if (pend_valid_ff) begin
            rsp_in       = pend_ff;
            rsp_in.last  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         pend_in       = push_item;
         pend_valid_in = 1'b1;
      end else if (flush && pend_valid_ff && out_free) begin
         rsp_in        = pend_ff;
         rsp_in.last   = 1'b1;
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.len, rsp_ff.handle, rsp_ff.miss, rsp_ff.seq};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

endmodule
`default_nettype wire

>>> src/sequence_reorder_playout_buffer.sv
// a reject result and released results leave through a pending stage, where the last result
// of an arrival (also a lone result) is held until the flush marks it last; the walk steps
// over the slots to release, closes an open missing run ahead of a delivery, folds a count
// beyond a full lap into the run and waits on output stalls; window, count, slot-age and tail
// sums share one 32-bit add/sub unit, the counter steps have their own adders; ready is low
// while an arrival is in work; reset (synchronous, active high) empties every ring slot,
// sets newest and next-release seq to 1 and last delivered seq to 0, no clearing pass
`default_nettype none
module sequence_reorder_playout_buffer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request beat: seq_num [31:0], payload_handle [47:32], payload_len [58:48]
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [sqrb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // response beat: seq_num_out [31:0], miss_count [63:32], handle_out [79:64],
   // len_out [90:80]
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [sqrb_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // response kind: kind [1:0]
   output logic [1:0]                             rsp_tuser,
   output logic                                   rsp_tlast
);
   import sqrb_pkg::*;

   // sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;   // waiting for a beat
   localparam logic [3:0] ST_CHK0 = 4'd1;   // newest - depth, newest < depth
   localparam logic [3:0] ST_CHK1 = 4'd2;   // window check on seq
   localparam logic [3:0] ST_CHK2 = 4'd3;   // raise newest
   localparam logic [3:0] ST_CNT0 = 4'd4;   // newest - half depth
   localparam logic [3:0] ST_CNT1 = 4'd5;   // release count
   localparam logic [3:0] ST_CNT2 = 4'd6;   // clip count to ring depth
   localparam logic [3:0] ST_WALK = 4'd7;   // one slot per cycle unless a run closes first or the output stalls
   localparam logic [3:0] ST_END0 = 4'd8;   // fold skipped tail into the run
   localparam logic [3:0] ST_END1 = 4'd9;   // advance next-release past the tail
   localparam logic [3:0] ST_RUN  = 4'd10;  // emit the open missing run
   localparam logic [3:0] ST_FIN  = 4'd11;  // store packet, mark last beat
   localparam logic [3:0] ST_REJ  = 4'd12;  // emit the reject result

   logic [3:0]       state_ff, state_in;

   // latched arrival
   logic [31:0]      seq_ff, seq_in;
   logic [15:0]      handle_ff, handle_in;
   logic [10:0]      len_ff, len_in;
   logic             accepted_ff, accepted_in;

   // sequencer scratch
   logic             flag_ff, flag_in;
   logic [31:0]      tmp_ff, tmp_in;
   logic [CNT_W-1:0] walk_cnt_ff, walk_cnt_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      run_start_ff, run_start_in;
   logic [31:0]      run_len_ff, run_len_in;

   // buffer state
   logic [31:0]      newest_ff, newest_in;
   logic [31:0]      next_ff, next_in;
   logic [31:0]      last_ff, last_in;

   // shared add/sub unit
   logic [31:0]      alu_a, alu_b, alu_res;
   logic             alu_sub, alu_borrow, alu_zero;

   // ring
   logic             ring_wr_en, ring_clr_en, ring_rd_valid;
   slot_entry_type   ring_wr_entry, ring_rd_entry;

   // result path
   logic             push_valid, push_ready, flush, flush_done;
   rsp_item_type     push_item;

   logic             deliverable;

   sqrb_alu u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sub    (alu_sub),
      .res    (alu_res),
      .borrow (alu_borrow),
      .zero   (alu_zero)
   );

   assign ring_wr_entry = '{seq: seq_ff, handle: handle_ff, len: len_ff};

   sqrb_ring u_ring (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (ring_wr_en),
      .wr_idx   (seq_ff[IDX_W-1:0]),
      .wr_entry (ring_wr_entry),
      .clr_en   (ring_clr_en),
      .rd_idx   (next_ff[IDX_W-1:0]),
      .rd_valid (ring_rd_valid),
      .rd_entry (ring_rd_entry)
   );

   sqrb_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .flush      (flush),
      .flush_done (flush_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign req_tready = (state_ff == ST_IDLE);

   // operand select for the shared unit
   always_comb begin
      alu_a   = newest_ff;
      alu_b   = 32'(RING_DEPTH);
      alu_sub = 1'b1;
      unique case (state_ff)
         ST_CHK1: begin
            alu_a = tmp_ff;
            alu_b = seq_ff;
         end
         ST_CHK2: begin
            alu_b = seq_ff;
         end
         ST_CNT0: begin
            alu_b = 32'(HALF_DEPTH);
         end
         ST_CNT1: begin
            alu_a = tmp_ff;
            alu_b = next_ff;
         end
         ST_CNT2: begin
            alu_a = tmp_ff;
         end
         ST_WALK: begin
            // borrow means slot seq is above the last delivered one
            alu_a = last_ff;
            alu_b = ring_rd_entry.seq;
         end
         ST_END0: begin
            alu_a   = run_len_ff;
            alu_b   = rem_ff;
            alu_sub = 1'b0;
         end
         ST_END1: begin
            alu_a   = next_ff;
            alu_b   = rem_ff;
            alu_sub = 1'b0;
         end
         default: begin
            alu_a = newest_ff;
         end
      endcase
   end

   assign deliverable = ring_rd_valid && alu_borrow;

   always_comb begin
      state_in     = state_ff;
      seq_in       = seq_ff;
      handle_in    = handle_ff;
      len_in       = len_ff;
      accepted_in  = accepted_ff;
      flag_in      = flag_ff;
      tmp_in       = tmp_ff;
      walk_cnt_in  = walk_cnt_ff;
      rem_in       = rem_ff;
      run_start_in = run_start_ff;
      run_len_in   = run_len_ff;
      newest_in    = newest_ff;
      next_in      = next_ff;
      last_in      = last_ff;
      ring_wr_en   = 1'b0;
      ring_clr_en  = 1'b0;
      push_valid   = 1'b0;
      flush        = 1'b0;
      push_item    = '{kind: KIND_MISS, seq: run_start_ff, miss: run_len_ff,
                       handle: 16'd0, len: 11'd0, last: 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               seq_in    = req_tdata[31:0];
               handle_in = req_tdata[47:32];
               len_in    = req_tdata[58:48];
               state_in  = ST_CHK0;
            end
         end
         ST_CHK0: begin
            tmp_in   = alu_res;
            flag_in  = alu_borrow;
            state_in = ST_CHK1;
         end
         ST_CHK1: begin
            // in window when newest is small or seq > newest - depth
            if (flag_ff || alu_borrow) begin
               accepted_in = 1'b1;
               state_in    = ST_CHK2;
            end else begin
               accepted_in = 1'b0;
               state_in    = ST_REJ;
            end
         end
         ST_CHK2: begin
            if (alu_borrow) begin
               newest_in = seq_ff;
            end
            state_in = ST_CNT0;
         end
         ST_CNT0: begin
            tmp_in   = alu_res;
            flag_in  = alu_borrow;
            state_in = ST_CNT1;
         end
         ST_CNT1: begin
            if (flag_ff || alu_borrow || alu_zero) begin
               walk_cnt_in = '0;
               rem_in      = 32'd0;
               state_in    = ST_RUN;
            end else begin
               tmp_in   = alu_res;
               state_in = ST_CNT2;
            end
         end
         ST_CNT2: begin
            if (alu_borrow) begin
               walk_cnt_in = tmp_ff[CNT_W-1:0];
               rem_in      = 32'd0;
            end else begin
               walk_cnt_in = CNT_W'(RING_DEPTH);
               rem_in      = alu_res;
            end
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (walk_cnt_ff == '0) begin
               state_in = ST_END0;
            end else if (deliverable && (run_len_ff != 32'd0)) begin
               // close the open run first, same slot again next cycle
               push_valid = 1'b1;
               if (push_ready) begin
                  run_len_in = 32'd0;
               end
            end else if (deliverable) begin
               push_valid = 1'b1;
               push_item  = '{kind: KIND_DELIVER, seq: ring_rd_entry.seq, miss: 32'd0,
                              handle: ring_rd_entry.handle, len: ring_rd_entry.len,
                              last: 1'b0};
               if (push_ready) begin
                  last_in     = ring_rd_entry.seq;
                  ring_clr_en = 1'b1;
                  next_in     = next_ff + 32'd1;
                  walk_cnt_in = walk_cnt_ff - CNT_W'(1);
               end
            end else begin
               // empty or stale slot joins the missing run
               if (run_len_ff == 32'd0) begin
                  run_start_in = next_ff;
               end
               run_len_in  = run_len_ff + 32'd1;
               ring_clr_en = 1'b1;
               next_in     = next_ff + 32'd1;
               walk_cnt_in = walk_cnt_ff - CNT_W'(1);
            end
         end
         ST_END0: begin
            if (rem_ff == 32'd0) begin
               state_in = ST_RUN;
            end else begin
               // every slot is empty now, the tail is all missing
               if (run_len_ff == 32'd0) begin
                  run_start_in = next_ff;
               end
               run_len_in = alu_res;
               state_in   = ST_END1;
            end
         end
         ST_END1: begin
            next_in  = alu_res;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (run_len_ff == 32'd0) begin
               state_in = ST_FIN;
            end else begin
               push_valid = 1'b1;
               if (push_ready) begin
                  run_len_in = 32'd0;
                  state_in   = ST_FIN;
               end
            end
         end
         ST_REJ: begin
            push_valid = 1'b1;
            push_item  = '{kind: KIND_REJECT, seq: seq_ff, miss: 32'd0,
                           handle: handle_ff, len: len_ff, last: 1'b0};
            if (push_ready) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            flush = 1'b1;
            if (flush_done) begin
               ring_wr_en = accepted_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         accepted_ff <= 1'b0;
         flag_ff     <= 1'b0;
         walk_cnt_ff <= '0;
         run_len_ff  <= 32'd0;
         newest_ff   <= 32'd1;
         next_ff     <= 32'd1;
         last_ff     <= 32'd0;
      end else begin
         state_ff    <= state_in;
         accepted_ff <= accepted_in;
         flag_ff     <= flag_in;
         walk_cnt_ff <= walk_cnt_in;
         run_len_ff  <= run_len_in;
         newest_ff   <= newest_in;
         next_ff     <= next_in;
         last_ff     <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff       <= seq_in;
      handle_ff    <= handle_in;
      len_ff       <= len_in;
      tmp_ff       <= tmp_in;
      rem_ff       <= rem_in;
      run_start_ff <= run_start_in;
   end

endmodule
`default_nettype wire

>>> src/sqrb_checker.sv
`default_nettype none
`include "sequence_reorder_playout_buffer_defines.svh"
module sqrb_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [sqrb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic [1:0]                        rsp_tuser,
   input  wire logic                              rsp_tlast
);
   import sqrb_pkg::*;

   // a stalled response beat holds
   `SQRB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   // a reject is the only result of its arrival
   `SQRB_ASSERT_NOW(a_reject_last, rsp_tvalid && (rsp_tuser == KIND_REJECT), rsp_tlast)
   // missing runs carry a nonzero count and no payload descriptor
   `SQRB_ASSERT_NOW(a_miss_fields, rsp_tvalid && (rsp_tuser == KIND_MISS), (rsp_tdata[63:32] != 32'd0) && (rsp_tdata[90:64] == 27'd0))
   // delivered and rejected beats carry no miss count
   `SQRB_ASSERT_NOW(a_no_count, rsp_tvalid && (rsp_tuser == KIND_DELIVER || rsp_tuser == KIND_REJECT), rsp_tdata[63:32] == 32'd0)
   // no new arrival is taken in the cycle after one was accepted
   `SQRB_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready)

endmodule

bind sequence_reorder_playout_buffer sqrb_checker u_sqrb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
